### hw/rtl/tzp_pkg.sv
// Shared types, constants and helper functions of the timezone string parser.
package tzp_pkg;

   // Default name buffer size; names keep at most NAME_BUFFER-1 characters.
   localparam int NAME_BUFFER = 32;

   // Depth of the job queue between parser front and emitter back.
   localparam int JOB_QUEUE_DEPTH = 2;

   // Result kinds.
   localparam logic [1:0] KIND_STD    = 2'd0;
   localparam logic [1:0] KIND_DST    = 2'd1;
   localparam logic [1:0] KIND_OFFSET = 2'd2;

   // Characters the parser looks for.
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LT    = 8'h3c;
   localparam logic [7:0] CH_GT    = 8'h3e;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_COLON = 8'h3a;

   // Field saturation limits.
   localparam logic [31:0] SAT_POS = 32'h7fff_ffff;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   // Seconds per hour and per minute.
   localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
   localparam logic [5:0]  SEC_PER_MIN  = 6'd60;

   // Offset fields handed from the parser to the emitter with each string.
   typedef struct packed {
      logic        offset_neg;
      logic [30:0] hour;
      logic [31:0] min_mag;
      logic        min_neg;
      logic [31:0] sec_mag;
      logic        sec_neg;
   } tzp_offset_type;

   // Emitter tells the top level that a name bank is free again.
   typedef struct packed {
      logic valid;
      logic bank;
   } tzp_release_type;

   function automatic logic is_letter(input logic [7:0] c);
      logic [7:0] l;
      l = c | 8'h20;
      return (l >= 8'h61) && (l <= 8'h7a);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d));
   endfunction

   // mag*10 + digit, saturated at cap.
   function automatic logic [31:0] accumulate(input logic [31:0] mag, input logic [7:0] c,
                                              input logic [31:0] cap);
      logic [34:0] v;
      v = {mag, 3'b000} + {2'b00, mag, 1'b0} + {31'd0, c[3:0]};
      if (v > {3'b000, cap}) begin
         return cap;
      end
      return v[31:0];
   endfunction

   // Substitute name for an empty standard name.
   function automatic logic [7:0] utc_char(input logic [1:0] idx);
      logic [7:0] r;
      unique case (idx)
         2'd0:    r = 8'h55;
         2'd1:    r = 8'h54;
         default: r = 8'h43;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/tzp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tzp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/tzp_job_queue.sv
// Small FIFO carrying finished parse jobs from the front to the back.
module tzp_job_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tzp_pkg::JOB_QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output logic [WIDTH-1:0] head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   // a push into a full queue would drop a whole string
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("job queue overflow");

endmodule

### hw/rtl/tzp_front.sv
// Parser front: one byte per ready cycle, tracks the TZ grammar, writes names.
module tzp_front #(
   parameter int NAME_BUFFER = tzp_pkg::NAME_BUFFER
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [7:0]                        req_ch,
   input  logic [1:0]                        bank_busy,
   input  logic                              queue_full,
   output logic                              job_push,
   output logic                              job_bank,
   output logic [$clog2(NAME_BUFFER)-1:0]    job_std_count,
   output logic [$clog2(NAME_BUFFER)-1:0]    job_dst_count,
   output tzp_pkg::tzp_offset_type           job_offset,
   output logic                              std_we,
   output logic [$clog2(NAME_BUFFER):0]      std_waddr,
   output logic [7:0]                        std_wdata,
   output logic                              dst_we,
   output logic [$clog2(NAME_BUFFER):0]      dst_waddr,
   output logic [7:0]                        dst_wdata
);

   localparam int CW = $clog2(NAME_BUFFER);

   localparam logic [3:0] PH_STD_START  = 4'd0;
   localparam logic [3:0] PH_STD_QUOTED = 4'd1;
   localparam logic [3:0] PH_STD_ALPHA  = 4'd2;
   localparam logic [3:0] PH_SIGN       = 4'd3;
   localparam logic [3:0] PH_HOUR_FIRST = 4'd4;
   localparam logic [3:0] PH_HOUR       = 4'd5;
   localparam logic [3:0] PH_MIN_START  = 4'd6;
   localparam logic [3:0] PH_MIN_SIGN   = 4'd7;
   localparam logic [3:0] PH_MIN_DIGITS = 4'd8;
   localparam logic [3:0] PH_SEC_START  = 4'd9;
   localparam logic [3:0] PH_SEC_SIGN   = 4'd10;
   localparam logic [3:0] PH_SEC_DIGITS = 4'd11;
   localparam logic [3:0] PH_DST_START  = 4'd12;
   localparam logic [3:0] PH_DST_QUOTED = 4'd13;
   localparam logic [3:0] PH_DST_ALPHA  = 4'd14;
   localparam logic [3:0] PH_IGNORE     = 4'd15;

   logic [3:0]    phase_ff, phase_in;
   logic [CW-1:0] std_count_ff, std_count_in;
   logic [CW-1:0] dst_count_ff, dst_count_in;
   logic          off_neg_ff, off_neg_in;
   logic [30:0]   hour_ff, hour_in;
   logic [31:0]   min_mag_ff, min_mag_in;
   logic          min_neg_ff, min_neg_in;
   logic [31:0]   sec_mag_ff, sec_mag_in;
   logic          sec_neg_ff, sec_neg_in;
   logic          tent_ff, tent_in;
   logic          bank_ff;

   logic          accept;
   logic          term;
   logic          put_std, put_dst;

   assign req_ready = !bank_busy[bank_ff] && !queue_full;
   assign accept    = req_valid && req_ready;
   assign term      = (req_ch == tzp_pkg::CH_NUL);

   // one byte of the grammar; a byte that ends a field is handed on to the
   // next phase in the same cycle (at most three hand-offs)
   always_comb begin
      logic [3:0]  ph;
      logic        again;
      logic        sec;
      logic [31:0] mag;
      logic        neg;
      logic [31:0] hacc;
      ph           = phase_ff;
      again        = 1'b1;
      sec          = 1'b0;
      mag          = '0;
      neg          = 1'b0;
      hacc         = '0;
      std_count_in = std_count_ff;
      dst_count_in = dst_count_ff;
      off_neg_in   = off_neg_ff;
      hour_in      = hour_ff;
      min_mag_in   = min_mag_ff;
      min_neg_in   = min_neg_ff;
      sec_mag_in   = sec_mag_ff;
      sec_neg_in   = sec_neg_ff;
      tent_in      = tent_ff;
      put_std      = 1'b0;
      put_dst      = 1'b0;
      for (int p = 0; p < 4; p++) begin
         if (again) begin
            again = 1'b0;
            unique case (ph)
               PH_STD_START: begin
                  if (req_ch == tzp_pkg::CH_LT) begin
                     ph = PH_STD_QUOTED;
                  end else if (tzp_pkg::is_letter(req_ch)) begin
                     put_std = 1'b1;
                     ph = PH_STD_ALPHA;
                  end else begin
                     ph = PH_SIGN;
                     again = 1'b1;
                  end
               end
               PH_STD_QUOTED: begin
                  if (req_ch == tzp_pkg::CH_GT) begin
                     ph = PH_SIGN;
                  end else begin
                     put_std = 1'b1;
                  end
               end
               PH_STD_ALPHA: begin
                  if (tzp_pkg::is_letter(req_ch)) begin
                     put_std = 1'b1;
                  end else begin
                     ph = PH_SIGN;
                     again = 1'b1;
                  end
               end
               PH_SIGN: begin
                  ph = PH_HOUR_FIRST;
                  if (req_ch == tzp_pkg::CH_MINUS) begin
                     off_neg_in = 1'b1;
                  end else if (req_ch != tzp_pkg::CH_PLUS) begin
                     again = 1'b1;
                  end
               end
               PH_HOUR_FIRST, PH_HOUR: begin
                  if (tzp_pkg::is_digit(req_ch)) begin
                     hacc = tzp_pkg::accumulate({1'b0, hour_in}, req_ch, tzp_pkg::SAT_POS);
                     hour_in = hacc[30:0];
                     ph = PH_HOUR;
                  end else if (ph == PH_HOUR && req_ch == tzp_pkg::CH_COLON) begin
                     ph = PH_MIN_START;
                  end else begin
                     ph = PH_DST_START;
                     again = 1'b1;
                  end
               end
               PH_MIN_START, PH_MIN_SIGN, PH_MIN_DIGITS,
               PH_SEC_START, PH_SEC_SIGN, PH_SEC_DIGITS: begin
                  sec = (ph >= PH_SEC_START);
                  mag = sec ? sec_mag_in : min_mag_in;
                  neg = sec ? sec_neg_in : min_neg_in;
                  if (ph == PH_MIN_DIGITS || ph == PH_SEC_DIGITS) begin
                     if (tzp_pkg::is_digit(req_ch)) begin
                        mag = tzp_pkg::accumulate(mag, req_ch, tzp_pkg::SAT_NEG);
                     end else if (!sec && req_ch == tzp_pkg::CH_COLON) begin
                        ph = PH_SEC_START;
                     end else begin
                        ph = PH_DST_START;
                        again = 1'b1;
                     end
                  end else if (tzp_pkg::is_digit(req_ch)) begin
                     tent_in = 1'b0;
                     ph = sec ? PH_SEC_DIGITS : PH_MIN_DIGITS;
                     mag = tzp_pkg::accumulate(mag, req_ch, tzp_pkg::SAT_NEG);
                  end else if ((ph == PH_MIN_START || ph == PH_SEC_START)
                               && tzp_pkg::is_space(req_ch)) begin
                     tent_in = 1'b1;
                  end else if ((ph == PH_MIN_START || ph == PH_SEC_START)
                               && (req_ch == tzp_pkg::CH_PLUS
                                   || req_ch == tzp_pkg::CH_MINUS)) begin
                     tent_in = 1'b1;
                     neg = (req_ch == tzp_pkg::CH_MINUS);
                     ph = sec ? PH_SEC_SIGN : PH_MIN_SIGN;
                  end else if ((ph == PH_MIN_START || ph == PH_SEC_START) && !tent_in) begin
                     if (!sec && req_ch == tzp_pkg::CH_COLON) begin
                        ph = PH_SEC_START;
                     end else begin
                        ph = PH_DST_START;
                        again = 1'b1;
                     end
                  end else begin
                     // prefix with no digit: field is zero, rest is dropped
                     neg = 1'b0;
                     mag = '0;
                     tent_in = 1'b0;
                     ph = PH_IGNORE;
                  end
                  if (sec) begin
                     sec_mag_in = mag;
                     sec_neg_in = neg;
                  end else begin
                     min_mag_in = mag;
                     min_neg_in = neg;
                  end
               end
               PH_DST_START: begin
                  if (req_ch == tzp_pkg::CH_LT) begin
                     ph = PH_DST_QUOTED;
                  end else if (tzp_pkg::is_letter(req_ch)) begin
                     put_dst = 1'b1;
                     ph = PH_DST_ALPHA;
                  end else begin
                     ph = PH_IGNORE;
                  end
               end
               PH_DST_QUOTED: begin
                  if (req_ch == tzp_pkg::CH_GT) begin
                     ph = PH_IGNORE;
                  end else begin
                     put_dst = 1'b1;
                  end
               end
               PH_DST_ALPHA: begin
                  if (tzp_pkg::is_letter(req_ch)) begin
                     put_dst = 1'b1;
                  end else begin
                     ph = PH_IGNORE;
                  end
               end
               PH_IGNORE: begin
                  ph = PH_IGNORE;
               end
            endcase
         end
      end
      phase_in = ph;
   end

   // name buffer writes; characters past the buffer are dropped
   always_comb begin
      std_we    = accept && !term && put_std && (std_count_ff < CW'(NAME_BUFFER - 1));
      dst_we    = accept && !term && put_dst && (dst_count_ff < CW'(NAME_BUFFER - 1));
      std_waddr = {bank_ff, std_count_ff};
      dst_waddr = {bank_ff, dst_count_ff};
      std_wdata = req_ch;
      dst_wdata = req_ch;
   end

   // job handed to the back at the terminator
   assign job_push      = accept && term;
   assign job_bank      = bank_ff;
   assign job_std_count = std_count_ff;
   assign job_dst_count = dst_count_ff;
   always_comb begin
      job_offset.offset_neg = off_neg_ff;
      job_offset.hour       = hour_ff;
      job_offset.min_mag    = min_mag_ff;
      job_offset.min_neg    = min_neg_ff;
      job_offset.sec_mag    = sec_mag_ff;
      job_offset.sec_neg    = sec_neg_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && term)) begin
         phase_ff     <= PH_STD_START;
         std_count_ff <= '0;
         dst_count_ff <= '0;
         off_neg_ff   <= 1'b0;
         hour_ff      <= '0;
         min_mag_ff   <= '0;
         min_neg_ff   <= 1'b0;
         sec_mag_ff   <= '0;
         sec_neg_ff   <= 1'b0;
         tent_ff      <= 1'b0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         std_count_ff <= std_we ? std_count_ff + 1'b1 : std_count_ff;
         dst_count_ff <= dst_we ? dst_count_ff + 1'b1 : dst_count_ff;
         off_neg_ff   <= off_neg_in;
         hour_ff      <= hour_in;
         min_mag_ff   <= min_mag_in;
         min_neg_ff   <= min_neg_in;
         sec_mag_ff   <= sec_mag_in;
         sec_neg_ff   <= sec_neg_in;
         tent_ff      <= tent_in;
      end
   end

   // next string goes to the other name bank
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
      end else if (accept && term) begin
         bank_ff <= !bank_ff;
      end
   end

   a_term_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && term) |=> (phase_ff == PH_STD_START) && (bank_ff != $past(bank_ff)))
      else $error("terminator did not restart the parser in the other bank");

   a_ignore_sticks: assert property (@(posedge clock) disable iff (reset)
      (accept && !term && phase_ff == PH_IGNORE) |=> (phase_ff == PH_IGNORE))
      else $error("parser left the ignore phase before the terminator");

   a_bank_free: assert property (@(posedge clock) disable iff (reset)
      (std_we || dst_we) |-> !bank_busy[bank_ff])
      else $error("name write into a bank still being emitted");

endmodule

### hw/rtl/tzp_back.sv
// Emitter back: computes the clamped offset and streams out names and summary.
module tzp_back #(
   parameter int NAME_BUFFER = tzp_pkg::NAME_BUFFER
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            job_valid,
   output logic                            job_pop,
   input  logic                            job_bank,
   input  logic [$clog2(NAME_BUFFER)-1:0]  job_std_count,
   input  logic [$clog2(NAME_BUFFER)-1:0]  job_dst_count,
   input  tzp_pkg::tzp_offset_type         job_offset,
   output logic [$clog2(NAME_BUFFER):0]    rd_addr,
   input  logic [7:0]                      std_rd_data,
   input  logic [7:0]                      dst_rd_data,
   output tzp_pkg::tzp_release_type        release_bank,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [7:0]                      rsp_name_char,
   output logic signed [31:0]              rsp_offset_seconds,
   output logic                            rsp_last
);

   localparam int CW = $clog2(NAME_BUFFER);
   localparam int UTC_LEN = (NAME_BUFFER - 1 < 3) ? NAME_BUFFER - 1 : 3;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_CLAMP = 3'd3;
   localparam logic [2:0] ST_STD   = 3'd4;
   localparam logic [2:0] ST_DST   = 3'd5;
   localparam logic [2:0] ST_SUM   = 3'd6;

   localparam logic [1:0] SRC_STD = 2'd0;
   localparam logic [1:0] SRC_DST = 2'd1;
   localparam logic [1:0] SRC_UTC = 2'd2;
   localparam logic [1:0] SRC_SUM = 2'd3;

   localparam logic signed [47:0] CLAMP_POS = 48'sh0000_7fff_ffff;
   localparam logic signed [47:0] CLAMP_NEG = -48'sh0000_7fff_ffff;

   logic [2:0]              state_ff, state_in;
   logic                    bank_ff;
   logic [CW-1:0]           scnt_ff, dcnt_ff;
   tzp_pkg::tzp_offset_type job_ff;
   logic [CW-1:0]           idx_ff, idx_in;

   logic [42:0]             p_hour_ff;
   logic signed [37:0]      p_min_ff;
   logic signed [31:0]      p_sec_ff;
   logic signed [47:0]      total_ff;
   logic signed [31:0]      offset_ff;

   logic                    iss_valid_ff, iss_valid_in;
   logic [1:0]              iss_src_ff, iss_src_in;
   logic [1:0]              iss_kind_ff, iss_kind_in;
   logic [1:0]              iss_utc_ff;

   // two-entry result FIFO
   logic [1:0]              of_kind_ff [2];
   logic [7:0]              of_char_ff [2];
   logic signed [31:0]      of_off_ff  [2];
   logic                    of_last_ff [2];
   logic                    of_wptr_ff, of_rptr_ff;
   logic [1:0]              of_count_ff;
   logic                    of_pop;
   logic [2:0]              reserved;
   logic                    can_issue;

   logic [1:0]              std_src, dst_src;
   logic [CW-1:0]           std_len, dst_len;
   logic signed [31:0]      min_val, sec_val;
   logic signed [47:0]      neg_total;

   assign of_pop    = rsp_valid && rsp_ready;
   assign reserved  = {1'b0, of_count_ff} + {2'b00, iss_valid_ff} - {2'b00, of_pop};
   assign can_issue = (reserved < 3'd2);
   assign job_pop   = (state_ff == ST_IDLE);
   assign rd_addr   = {bank_ff, idx_ff};

   // empty standard name becomes UTC; empty daylight name copies standard
   assign std_src = (scnt_ff == '0) ? SRC_UTC : SRC_STD;
   assign std_len = (scnt_ff == '0) ? CW'(UTC_LEN) : scnt_ff;
   assign dst_src = (dcnt_ff == '0) ? std_src : SRC_DST;
   assign dst_len = (dcnt_ff == '0) ? std_len : dcnt_ff;

   // signed field values
   always_comb begin
      if (job_ff.min_neg) begin
         min_val = 32'(-$signed({1'b0, job_ff.min_mag}));
      end else begin
         min_val = (job_ff.min_mag > tzp_pkg::SAT_POS) ? $signed(tzp_pkg::SAT_POS)
                                                       : $signed(job_ff.min_mag);
      end
      if (job_ff.sec_neg) begin
         sec_val = 32'(-$signed({1'b0, job_ff.sec_mag}));
      end else begin
         sec_val = (job_ff.sec_mag > tzp_pkg::SAT_POS) ? $signed(tzp_pkg::SAT_POS)
                                                       : $signed(job_ff.sec_mag);
      end
   end

   assign neg_total = job_ff.offset_neg ? -total_ff : total_ff;

   // sequencer: arithmetic, then standard name, daylight name, summary
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      iss_valid_in = 1'b0;
      iss_src_in   = SRC_SUM;
      iss_kind_in  = tzp_pkg::KIND_OFFSET;
      release_bank.valid = 1'b0;
      release_bank.bank  = bank_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_STD;
         ST_STD: begin
            if (can_issue) begin
               iss_valid_in = 1'b1;
               iss_src_in   = std_src;
               iss_kind_in  = tzp_pkg::KIND_STD;
               if (idx_ff == std_len - 1'b1) begin
                  idx_in   = '0;
                  state_in = ST_DST;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_DST: begin
            if (can_issue) begin
               iss_valid_in = 1'b1;
               iss_src_in   = dst_src;
               iss_kind_in  = tzp_pkg::KIND_DST;
               if (idx_ff == dst_len - 1'b1) begin
                  idx_in   = '0;
                  state_in = ST_SUM;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         ST_SUM: begin
            if (can_issue) begin
               iss_valid_in       = 1'b1;
               iss_src_in         = SRC_SUM;
               iss_kind_in        = tzp_pkg::KIND_OFFSET;
               release_bank.valid = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         iss_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         iss_valid_ff <= iss_valid_in;
      end
   end

   // job capture and offset arithmetic
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && job_valid) begin
         bank_ff <= job_bank;
         scnt_ff <= job_std_count;
         dcnt_ff <= job_dst_count;
         job_ff  <= job_offset;
      end
      if (state_ff == ST_MUL) begin
         p_hour_ff <= {12'd0, job_ff.hour} * {31'd0, tzp_pkg::SEC_PER_HOUR};
         p_min_ff  <= 38'({{6{min_val[31]}}, min_val} * $signed({32'd0, tzp_pkg::SEC_PER_MIN}));
         p_sec_ff  <= sec_val;
      end
      if (state_ff == ST_ADD) begin
         total_ff <= $signed({5'd0, p_hour_ff}) + {{10{p_min_ff[37]}}, p_min_ff}
                     + {{16{p_sec_ff[31]}}, p_sec_ff};
      end
      if (state_ff == ST_CLAMP) begin
         if (neg_total > CLAMP_POS) begin
            offset_ff <= CLAMP_POS[31:0];
         end else if (neg_total < CLAMP_NEG) begin
            offset_ff <= CLAMP_NEG[31:0];
         end else begin
            offset_ff <= neg_total[31:0];
         end
      end
      iss_src_ff  <= iss_src_in;
      iss_kind_ff <= iss_kind_in;
      iss_utc_ff  <= 2'(idx_ff);
   end

   // result FIFO: filled in the cycle after issue, when RAM data is ready
   always_ff @(posedge clock) begin
      if (iss_valid_ff) begin
         of_kind_ff[of_wptr_ff] <= iss_kind_ff;
         of_last_ff[of_wptr_ff] <= (iss_src_ff == SRC_SUM);
         of_off_ff[of_wptr_ff]  <= (iss_src_ff == SRC_SUM) ? offset_ff : 32'sd0;
         unique case (iss_src_ff)
            SRC_STD: of_char_ff[of_wptr_ff] <= std_rd_data;
            SRC_DST: of_char_ff[of_wptr_ff] <= dst_rd_data;
            SRC_UTC: of_char_ff[of_wptr_ff] <= tzp_pkg::utc_char(iss_utc_ff);
            SRC_SUM: of_char_ff[of_wptr_ff] <= 8'd0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         of_wptr_ff  <= 1'b0;
         of_rptr_ff  <= 1'b0;
         of_count_ff <= 2'd0;
      end else begin
         of_wptr_ff  <= of_wptr_ff ^ iss_valid_ff;
         of_rptr_ff  <= of_rptr_ff ^ of_pop;
         of_count_ff <= of_count_ff + {1'b0, iss_valid_ff} - {1'b0, of_pop};
      end
   end

   assign rsp_valid          = (of_count_ff != 2'd0);
   assign rsp_kind           = of_kind_ff[of_rptr_ff];
   assign rsp_name_char      = of_char_ff[of_rptr_ff];
   assign rsp_offset_seconds = of_off_ff[of_rptr_ff];
   assign rsp_last           = of_last_ff[of_rptr_ff];

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      of_count_ff <= 2'd2)
      else $error("result FIFO overfilled");

   a_last_on_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_kind == tzp_pkg::KIND_OFFSET))
      else $error("last flag on a name character");

   a_release_after_issue: assert property (@(posedge clock) disable iff (reset)
      release_bank.valid |=> (state_ff == ST_IDLE) && iss_valid_ff)
      else $error("bank released without issuing the summary");

endmodule

### hw/rtl/tz_offset_string_parser.sv
// Top level of the timezone string parser: front, job queue, name RAMs, back.
// Throughput: one byte accepted per cycle; results leave at one per cycle while rsp_ready is high,
//   except between strings, while the back picks up the next job and runs its offset arithmetic.
// Path of a string's first result after its zero byte is accepted: job queue, job pickup,
//   three offset arithmetic stages, RAM read, result register.
// Input stalls only while both name banks wait to be emitted; sync reset clears control only.
module tz_offset_string_parser #(
   parameter int NAME_BUFFER = tzp_pkg::NAME_BUFFER
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_name_char,
   output logic signed [31:0] rsp_offset_seconds,
   output logic               rsp_last
);

   localparam int CW = $clog2(NAME_BUFFER);
   localparam int AW = CW + 1;
   localparam int OW = $bits(tzp_pkg::tzp_offset_type);
   localparam int JW = 1 + 2 * CW + OW;

   logic                     job_push, job_bank, queue_full;
   logic [CW-1:0]            job_std_count, job_dst_count;
   tzp_pkg::tzp_offset_type  job_offset;
   logic [JW-1:0]            q_head;
   logic                     q_valid, q_pop;
   logic                     std_we, dst_we;
   logic [AW-1:0]            std_waddr, dst_waddr, rd_addr;
   logic [7:0]               std_wdata, dst_wdata, std_rd_data, dst_rd_data;
   tzp_pkg::tzp_release_type release_bank;
   logic [1:0]               bank_busy_ff;

   tzp_front #(.NAME_BUFFER(NAME_BUFFER)) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_ch(req_ch),
      .bank_busy(bank_busy_ff), .queue_full(queue_full),
      .job_push(job_push), .job_bank(job_bank),
      .job_std_count(job_std_count), .job_dst_count(job_dst_count),
      .job_offset(job_offset),
      .std_we(std_we), .std_waddr(std_waddr), .std_wdata(std_wdata),
      .dst_we(dst_we), .dst_waddr(dst_waddr), .dst_wdata(dst_wdata)
   );

   tzp_job_queue #(.WIDTH(JW), .DEPTH(tzp_pkg::JOB_QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push(job_push), .push_data({job_bank, job_std_count, job_dst_count, job_offset}),
      .full(queue_full),
      .pop(q_pop), .head_valid(q_valid), .head_data(q_head)
   );

   // two banks of names each, selected by the top address bit
   tzp_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_std_ram (
      .clock(clock), .wr_en(std_we), .wr_addr(std_waddr), .wr_data(std_wdata),
      .rd_addr(rd_addr), .rd_data(std_rd_data)
   );

   tzp_ram #(.WIDTH(8), .DEPTH(2 ** AW)) u_dst_ram (
      .clock(clock), .wr_en(dst_we), .wr_addr(dst_waddr), .wr_data(dst_wdata),
      .rd_addr(rd_addr), .rd_data(dst_rd_data)
   );

   tzp_back #(.NAME_BUFFER(NAME_BUFFER)) u_back (
      .clock(clock), .reset(reset),
      .job_valid(q_valid), .job_pop(q_pop),
      .job_bank(q_head[JW-1]),
      .job_std_count(q_head[JW-2 -: CW]),
      .job_dst_count(q_head[JW-2-CW -: CW]),
      .job_offset(tzp_pkg::tzp_offset_type'(q_head[OW-1:0])),
      .rd_addr(rd_addr), .std_rd_data(std_rd_data), .dst_rd_data(dst_rd_data),
      .release_bank(release_bank),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_name_char(rsp_name_char), .rsp_offset_seconds(rsp_offset_seconds),
      .rsp_last(rsp_last)
   );

   // bank held from its terminator transfer until its summary is issued
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_busy_ff <= 2'b00;
      end else begin
         for (int b = 0; b < 2; b++) begin
            if (job_push && job_bank == 1'(b)) begin
               bank_busy_ff[b] <= 1'b1;
            end else if (release_bank.valid && release_bank.bank == 1'(b)) begin
               bank_busy_ff[b] <= 1'b0;
            end
         end
      end
   end

   a_no_ready_both_busy: assert property (@(posedge clock) disable iff (reset)
      (bank_busy_ff == 2'b11) |-> !req_ready)
      else $error("input ready while both name banks are busy");

endmodule

### tb/tz_offset_string_parser_tb.sv
// Testbench for the timezone string parser: directed and random strings, scoreboard, stalls.
module tz_offset_string_parser_tb;

   // Expected result of the parser
   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         name_char;
      logic signed [31:0] offset_seconds;
      logic               last;
   } tz_result_type;

   localparam int NB = tzp_pkg::NAME_BUFFER;

   // Parse phases
   typedef enum int {
      P_STD_START, P_STD_QUOTED, P_STD_ALPHA, P_SIGN, P_HOUR_FIRST, P_HOUR,
      P_MIN_START, P_MIN_SIGN, P_MIN_DIGITS, P_SEC_START, P_SEC_SIGN, P_SEC_DIGITS,
      P_DST_START, P_DST_QUOTED, P_DST_ALPHA, P_IGNORE
   } tz_phase_type;

   // Predictor and store of expected results
   class tz_scoreboard;
      tz_phase_type  ph;
      logic [7:0]    std_name[NB];
      logic [7:0]    dst_name[NB];
      int            std_len, dst_len;
      bit            off_neg, min_neg, sec_neg, prefix;
      longint        hour, min_mag, sec_mag;
      tz_result_type pending[$];
      int            errors, strings, results;

      function void clear();
         ph = P_STD_START; std_len = 0; dst_len = 0;
         off_neg = 0; min_neg = 0; sec_neg = 0; prefix = 0;
         hour = 0; min_mag = 0; sec_mag = 0;
      endfunction

      function bit letter(logic [7:0] c);
         logic [7:0] l;
         l = c | 8'h20;
         return l >= "a" && l <= "z";
      endfunction
      function bit digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction
      function bit space(logic [7:0] c);
         return c == " " || (c >= 9 && c <= 13);
      endfunction
      function longint acc(longint m, logic [7:0] c, longint cap);
         longint v;
         v = m * 10 + (c - "0");
         return v > cap ? cap : v;
      endfunction
      function longint field(longint m, bit n);
         if (n) return -m;
         return m > 64'sd2147483647 ? 64'sd2147483647 : m;
      endfunction

      function void push(logic [1:0] k, logic [7:0] ch, longint off, bit l);
         tz_result_type r;
         r.kind = k; r.name_char = ch; r.offset_seconds = off[31:0]; r.last = l;
         pending.push_back(r);
      endfunction

      // Minute or second field byte; returns 1 to reprocess the byte
      function bit number_byte(logic [7:0] c, bit sec);
         tz_phase_type st, sg, dg;
         st = sec ? P_SEC_START : P_MIN_START;
         sg = sec ? P_SEC_SIGN : P_MIN_SIGN;
         dg = sec ? P_SEC_DIGITS : P_MIN_DIGITS;
         if (ph == dg) begin
            if (digit(c)) begin
               if (sec) sec_mag = acc(sec_mag, c, 64'sd2147483648);
               else min_mag = acc(min_mag, c, 64'sd2147483648);
               return 0;
            end
            if (!sec && c == tzp_pkg::CH_COLON) begin
               ph = P_SEC_START;
               return 0;
            end
            ph = P_DST_START;
            return 1;
         end
         if (digit(c)) begin
            prefix = 0; ph = dg;
            if (sec) sec_mag = acc(sec_mag, c, 64'sd2147483648);
            else min_mag = acc(min_mag, c, 64'sd2147483648);
            return 0;
         end
         if (ph == st) begin
            if (space(c)) begin
               prefix = 1;
               return 0;
            end
            if (c == tzp_pkg::CH_PLUS || c == tzp_pkg::CH_MINUS) begin
               prefix = 1; ph = sg;
               if (sec) sec_neg = (c == tzp_pkg::CH_MINUS);
               else min_neg = (c == tzp_pkg::CH_MINUS);
               return 0;
            end
            if (!prefix) begin
               if (!sec && c == tzp_pkg::CH_COLON) begin
                  ph = P_SEC_START;
                  return 0;
               end
               ph = P_DST_START;
               return 1;
            end
         end
         if (sec) begin
            sec_neg = 0; sec_mag = 0;
         end else begin
            min_neg = 0; min_mag = 0;
         end
         prefix = 0; ph = P_IGNORE;
         return 0;
      endfunction

      // Note one accepted input byte
      function void note_byte(logic [7:0] c);
         logic [7:0] sn[NB];
         int n;
         longint tot;
         bit again;
         if (c == tzp_pkg::CH_NUL) begin
            n = std_len;
            for (int i = 0; i < n; i++) sn[i] = std_name[i];
            if (n == 0) begin
               sn[0] = "U"; sn[1] = "T"; sn[2] = "C"; n = 3;
            end
            tot = hour * 3600 + field(min_mag, min_neg) * 60 + field(sec_mag, sec_neg);
            if (off_neg) tot = -tot;
            if (tot > 64'sd2147483647) tot = 64'sd2147483647;
            else if (tot < -64'sd2147483647) tot = -64'sd2147483647;
            for (int i = 0; i < n; i++) push(tzp_pkg::KIND_STD, sn[i], 0, 0);
            if (dst_len == 0) for (int i = 0; i < n; i++) push(tzp_pkg::KIND_DST, sn[i], 0, 0);
            else for (int i = 0; i < dst_len; i++) push(tzp_pkg::KIND_DST, dst_name[i], 0, 0);
            push(tzp_pkg::KIND_OFFSET, 0, tot, 1);
            strings++;
            clear();
            return;
         end
         again = 1;
         while (again) begin
            again = 0;
            case (ph)
               P_STD_START:
                  if (c == tzp_pkg::CH_LT) ph = P_STD_QUOTED;
                  else if (letter(c)) begin
                     put_std(c); ph = P_STD_ALPHA;
                  end else begin
                     ph = P_SIGN; again = 1;
                  end
               P_STD_QUOTED:
                  if (c == tzp_pkg::CH_GT) ph = P_SIGN; else put_std(c);
               P_STD_ALPHA:
                  if (letter(c)) put_std(c);
                  else begin
                     ph = P_SIGN; again = 1;
                  end
               P_SIGN: begin
                  ph = P_HOUR_FIRST;
                  if (c == tzp_pkg::CH_MINUS) off_neg = 1;
                  else if (c != tzp_pkg::CH_PLUS) again = 1;
               end
               P_HOUR_FIRST, P_HOUR:
                  if (digit(c)) begin
                     hour = acc(hour, c, 64'sd2147483647); ph = P_HOUR;
                  end else if (ph == P_HOUR && c == tzp_pkg::CH_COLON) ph = P_MIN_START;
                  else begin
                     ph = P_DST_START; again = 1;
                  end
               P_MIN_START, P_MIN_SIGN, P_MIN_DIGITS: again = number_byte(c, 0);
               P_SEC_START, P_SEC_SIGN, P_SEC_DIGITS: again = number_byte(c, 1);
               P_DST_START:
                  if (c == tzp_pkg::CH_LT) ph = P_DST_QUOTED;
                  else if (letter(c)) begin
                     put_dst(c); ph = P_DST_ALPHA;
                  end else ph = P_IGNORE;
               P_DST_QUOTED:
                  if (c == tzp_pkg::CH_GT) ph = P_IGNORE; else put_dst(c);
               P_DST_ALPHA:
                  if (letter(c)) put_dst(c); else ph = P_IGNORE;
               default: ;
            endcase
         end
      endfunction

      function void put_std(logic [7:0] c);
         if (std_len < NB - 1) begin
            std_name[std_len] = c; std_len++;
         end
      endfunction
      function void put_dst(logic [7:0] c);
         if (dst_len < NB - 1) begin
            dst_name[dst_len] = c; dst_len++;
         end
      endfunction

      // Compare one result transfer with the oldest expectation
      function void check_result(tz_result_type got);
         tz_result_type exp_r;
         results++;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result kind=%0d char=%h off=%0d last=%0d", $time,
                     got.kind, got.name_char, got.offset_seconds, got.last);
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         if (got.kind !== exp_r.kind || got.name_char !== exp_r.name_char ||
             got.offset_seconds !== exp_r.offset_seconds || got.last !== exp_r.last) begin
            $display("%0t: mismatch expected kind=%0d char=%h off=%0d last=%0d", $time,
                     exp_r.kind, exp_r.name_char, exp_r.offset_seconds, exp_r.last);
            $display("%0t:          actual   kind=%0d char=%h off=%0d last=%0d", $time,
                     got.kind, got.name_char, got.offset_seconds, got.last);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic [7:0]         req_ch = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [1:0]         rsp_kind;
   logic [7:0]         rsp_name_char;
   logic signed [31:0] rsp_offset_seconds;
   logic               rsp_last;

   tz_scoreboard sb = new();
   int  send_idle_pct = 8;
   int  recv_idle_pct = 80;
   bit  hold_off = 0;
   byte unsigned str_q[$];

   tz_offset_string_parser u_top (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // Receiver: random stall, sample on rising edge
   always @(posedge clock) begin
      tz_result_type r;
      if (!reset && rsp_valid && rsp_ready) begin
         r.kind = rsp_kind; r.name_char = rsp_name_char;
         r.offset_seconds = rsp_offset_seconds; r.last = rsp_last;
         sb.check_result(r);
      end
   end
   always @(negedge clock)
      rsp_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);

   // Send one byte with random idle before it; valid stays up between bytes
   task automatic send_byte(byte unsigned c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_ch <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_byte(c);
      @(negedge clock);
   endtask

   task automatic send_string();
      foreach (str_q[i]) send_byte(str_q[i]);
      send_byte(0);
      str_q.delete();
   endtask

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
   endtask

   function automatic byte unsigned rand_letter();
      byte unsigned b;
      b = "A" + $urandom_range(25);
      return $urandom_range(1) ? (b | 8'h20) : b;
   endfunction

   function automatic byte unsigned rand_digit();
      return "0" + $urandom_range(9);
   endfunction

   // Random name, mostly short, sometimes quoted with any nonzero bytes
   task automatic add_name();
      int n;
      n = ($urandom_range(15) == 0) ? $urandom_range(40) : $urandom_range(1, 5);
      if ($urandom_range(3) == 0) begin
         str_q.push_back(tzp_pkg::CH_LT);
         repeat (n) str_q.push_back($urandom_range(1, 255));
         if ($urandom_range(7) != 0) str_q.push_back(tzp_pkg::CH_GT);
      end else repeat (n) str_q.push_back(rand_letter());
   endtask

   task automatic add_number();
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 2);
      if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2))
         str_q.push_back($urandom_range(1) ? " " : 9 + $urandom_range(4));
      if ($urandom_range(3) == 0)
         str_q.push_back($urandom_range(1) ? tzp_pkg::CH_MINUS : tzp_pkg::CH_PLUS);
      repeat (n) str_q.push_back(rand_digit());
   endtask

   // Mostly well-formed TZ strings with random content; some noise
   task automatic random_string();
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(6)) str_q.push_back($urandom_range(1, 255));
         return;
      end
      if ($urandom_range(7) != 0) add_name();
      case ($urandom_range(3))
         0: ;
         1: str_q.push_back(tzp_pkg::CH_PLUS);
         default: str_q.push_back(tzp_pkg::CH_MINUS);
      endcase
      repeat ($urandom_range(1, 2)) str_q.push_back(rand_digit());
      if ($urandom_range(2) != 0) begin
         str_q.push_back(tzp_pkg::CH_COLON);
         add_number();
         if ($urandom_range(1)) begin
            str_q.push_back(tzp_pkg::CH_COLON);
            add_number();
         end
      end
      if ($urandom_range(3) != 0) add_name();
      if ($urandom_range(2) == 0) add_text(",M3.2.0,M11.1.0");
   endtask

   task automatic run_random(int n_bytes);
      int sent;
      sent = 0;
      while (sent < n_bytes) begin
         random_string();
         sent += str_q.size() + 1;
         send_string();
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // Watchdog
   initial begin
      #5_000_000;
      $display("** tz_offset_string_parser: FAILED **");
      $finish;
   end

   initial begin
      sb.clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed strings: empty, plain, quoted, signs, prefixes, saturation
      send_string();
      add_text("EST5EDT"); send_string();
      add_text("<+0530>-5:30<X>"); send_string();
      add_text("<UNCLOSED"); send_string();
      add_text("-ABC"); send_string();
      add_text("CET-1:  -x"); send_string();
      add_text("A1::30B"); send_string();
      add_text("Z99999999999:-99999999999:99999999999Q"); send_string();
      add_text("abcdefghijklmnopqrstuvwxyzABCDEFGHIJ1"); send_string();
      str_q.push_back(8'hff); str_q.push_back(8'h80); send_string();
      add_text("<"); str_q.push_back(8'hff); add_text(">+2:\t+7:-5D"); send_string();
      add_text("X-2147483647"); send_string();
      drain();

      run_random(65);
      drain();
      send_idle_pct = 80; recv_idle_pct = 8;
      run_random(65);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      // Long receiver hold-off while strings keep coming
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         run_random(70);
      join
      drain();

      $display("Covered %0d strings, %0d result transfers checked, under mixed stalls.",
               sb.strings, sb.results);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("** tz_offset_string_parser: PASSED **");
      else
         $display("** tz_offset_string_parser: FAILED **");
      $finish;
   end
endmodule
